### rtl/amvd_pkg.sv
// Package for the accelerometer motion vote detector.
// Holds field widths, the sample struct, register map constants and the axis join.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package amvd_pkg;

  // Field and datapath widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned AXIS_W     = 10;
  localparam int unsigned DIFF_W     = AXIS_W + 1;
  localparam int unsigned THRESH_W   = 11;
  localparam int unsigned COUNT_W    = 2;
  localparam int unsigned IN_DATA_W  = 6 * BYTE_W;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd255;

  // Register word index, taken from paddr bit 2
  typedef enum logic {
    REG_THRESHOLD = 1'b0
  } amvd_reg_t;

  // One decoded sample, raw 10-bit two's complement patterns
  typedef struct packed {
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [AXIS_W-1:0] z;
  } amvd_sample_t;

  // Join the low byte with bits 1:0 of the high byte
  function automatic logic [AXIS_W-1:0] join_axis(input logic [BYTE_W-1:0] lo,
                                                  input logic [BYTE_W-1:0] hi);
    join_axis = {hi[AXIS_W-BYTE_W-1:0], lo};
  endfunction

endpackage

### rtl/amvd_axis_decode.sv
// Input stage of the motion vote detector: accepts a sample request and
// registers the three joined 10-bit axis values. Depends on amvd_pkg.
module amvd_axis_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high from bit 0 up
  input  logic [amvd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            smp_valid,
  output amvd_pkg::amvd_sample_t          smp,
  input  logic                            smp_ready
);

  logic                   valid_r;
  logic                   valid_nxt;
  amvd_pkg::amvd_sample_t smp_r;
  amvd_pkg::amvd_sample_t smp_nxt;
  logic                   take;

  // Stage is free when empty or draining this cycle
  assign in_tready = !valid_r || smp_ready;
  assign take      = in_tvalid && in_tready;

  // Join the bytes of each axis
  always_comb begin
    smp_nxt.x = amvd_pkg::join_axis(in_tdata[7:0],   in_tdata[15:8]);
    smp_nxt.y = amvd_pkg::join_axis(in_tdata[23:16], in_tdata[31:24]);
    smp_nxt.z = amvd_pkg::join_axis(in_tdata[39:32], in_tdata[47:40]);
    valid_nxt = take || (valid_r && !smp_ready);
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload on each accepted request
  always_ff @(posedge clk) begin
    if (take) begin
      smp_r <= smp_nxt;
    end
  end

  assign smp_valid = valid_r;
  assign smp       = smp_r;

endmodule

### rtl/amvd_vote.sv
// Vote stage of the motion vote detector: compares each axis with its previous
// sample, counts axes over threshold and registers the result. Depends on amvd_pkg.
module amvd_vote (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                smp_valid,
  input  amvd_pkg::amvd_sample_t              smp,
  output logic                                smp_ready,
  input  logic [amvd_pkg::THRESH_W-1:0]       threshold,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // motion_detected, axes_exceeded[1:0], zero fill from bit 0 up
  output logic [amvd_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [amvd_pkg::OUT_DATA_W-1:0]   res_r;
  logic [amvd_pkg::OUT_DATA_W-1:0]   res_nxt;
  amvd_pkg::amvd_sample_t            prev_r;
  logic                              take;
  logic                              ex_x;
  logic                              ex_y;
  logic                              ex_z;
  logic [amvd_pkg::COUNT_W-1:0]      count;

  // Two's complement negate at difference width
  function automatic logic [amvd_pkg::DIFF_W-1:0] DIFF_W_NEG(
      input logic [amvd_pkg::DIFF_W-1:0] v);
    DIFF_W_NEG = ~v + {{(amvd_pkg::DIFF_W-1){1'b0}}, 1'b1};
  endfunction

  // 1 when |cur - old| is strictly above the threshold
  function automatic logic exceeds(input logic [amvd_pkg::AXIS_W-1:0]   cur,
                                   input logic [amvd_pkg::AXIS_W-1:0]   old,
                                   input logic [amvd_pkg::THRESH_W-1:0] thr);
    logic signed [amvd_pkg::DIFF_W-1:0] d;
    logic [amvd_pkg::DIFF_W-1:0]        mag;
    d   = $signed({cur[amvd_pkg::AXIS_W-1], cur}) - $signed({old[amvd_pkg::AXIS_W-1], old});
    mag = d[amvd_pkg::DIFF_W-1] ? DIFF_W_NEG(d) : d;
    // Magnitude and threshold share the same 11-bit width
    exceeds = (mag > thr);
  endfunction

  assign smp_ready = !out_valid_r || out_tready;
  assign take      = smp_valid && smp_ready;

  // Compare and count the votes
  always_comb begin
    ex_x  = exceeds(smp.x, prev_r.x, threshold);
    ex_y  = exceeds(smp.y, prev_r.y, threshold);
    ex_z  = exceeds(smp.z, prev_r.z, threshold);
    count = {1'b0, ex_x} + {1'b0, ex_y} + {1'b0, ex_z};
    res_nxt = {{(amvd_pkg::OUT_DATA_W-amvd_pkg::COUNT_W-1){1'b0}}, count, count[1]};
    out_valid_nxt = take || (out_valid_r && !out_tready);
  end

  // Hold result valid and the previous samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        prev_r <= smp;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

### rtl/accel_motion_vote_detector_top.sv
// An accepted input request passes the input register, then the result register,
// to out_tdata. Throughput: one request per cycle while out_tready is high; set by
// the input register and result register, each of which refills in the cycle it drains.
// Reset: synchronous active-low rst_n empties both stages, clears the previous
// samples to zero and sets the threshold to 255.
// Top level; instantiates amvd_axis_decode and amvd_vote, depends on amvd_pkg.
module accel_motion_vote_detector_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high from bit 0 up
  input  logic [amvd_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // motion_detected, axes_exceeded[1:0], zero fill from bit 0 up
  output logic [amvd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [amvd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [amvd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [amvd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  logic [amvd_pkg::THRESH_W-1:0] threshold_r;
  logic                          cfg_wr;
  logic                          smp_valid;
  logic                          smp_ready;
  amvd_pkg::amvd_sample_t        smp;

  // Register file: threshold at word 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == amvd_pkg::REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= amvd_pkg::THRESH_RESET;
    end else if (cfg_wr) begin
      threshold_r <= cfg_pwdata[amvd_pkg::THRESH_W-1:0];
    end
  end

  // Read back the threshold, zero above it
  always_comb begin
    if (cfg_paddr[2] == amvd_pkg::REG_THRESHOLD) begin
      cfg_prdata = {{(amvd_pkg::CFG_DATA_W-amvd_pkg::THRESH_W){1'b0}}, threshold_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  amvd_axis_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready)
  );

  amvd_vote u_vote (
    .clk        (clk),
    .rst_n      (rst_n),
    .smp_valid  (smp_valid),
    .smp        (smp),
    .smp_ready  (smp_ready),
    .threshold  (threshold_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/amvd_checker.sv
// Port-level checker for the motion vote detector, bound to the top level.
// Depends on amvd_pkg and on the top level's port names.
module amvd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [amvd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                              cfg_pready
);

  // Stalled result request stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  // Motion flag agrees with the vote count
  a_motion_vote: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == out_tdata[2]))
    else $error("motion flag disagrees with axes count");

  // Fill bits stay zero
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:3] == 5'd0))
    else $error("nonzero fill bits in result");

  // No result in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // Configuration port never waits
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind accel_motion_vote_detector_top amvd_checker u_amvd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

### tb/accel_motion_vote_detector_top_test.sv
// Self-checking testbench for accel_motion_vote_detector_top: stream traffic plus
// APB threshold writes, results checked against an in-bench motion vote predictor.
// Depends on amvd_pkg and the RTL top level only.
module accel_motion_vote_detector_top_test;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 80;
  localparam int PHASE_COUNT  = 8;
  localparam int REPORT_LIMIT = 10;
  localparam logic [amvd_pkg::CFG_ADDR_W-1:0] THRESH_ADDR = {amvd_pkg::REG_THRESHOLD, 2'b00};

  // One result: motion flag and number of axes over threshold
  typedef struct packed {
    logic       motion;
    logic [1:0] axes;
  } vote_t;

  // One directed row; vote is used only when typed is set
  typedef struct packed {
    logic [amvd_pkg::IN_DATA_W-1:0] data;
    bit                             typed;
    vote_t                          vote;
  } dir_row_t;

  logic                              clk         = 1'b0;
  logic                              rst_n       = 1'b0;
  logic                              in_tvalid   = 1'b0;
  logic                              in_tready;
  // x_low, x_high, y_low, y_high, z_low, z_high from bit 0 up
  logic [amvd_pkg::IN_DATA_W-1:0]    in_tdata    = '0;
  logic                              out_tvalid;
  logic                              out_tready  = 1'b0;
  // motion_detected, axes_exceeded[1:0], zero fill from bit 0 up
  logic [amvd_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                              cfg_psel    = 1'b0;
  logic                              cfg_penable = 1'b0;
  logic                              cfg_pwrite  = 1'b0;
  logic [amvd_pkg::CFG_ADDR_W-1:0]   cfg_paddr   = '0;
  logic [amvd_pkg::CFG_DATA_W-1:0]   cfg_pwdata  = '0;
  logic [amvd_pkg::CFG_DATA_W-1:0]   cfg_prdata;
  logic                              cfg_pready;

  // Typed expectation travels beside the request it belongs to
  bit    row_typed = 1'b0;
  vote_t row_vote  = '0;

  // Predictor state and checking bookkeeping
  vote_t                  vote_q[$];
  dir_row_t               dir_rows[$];
  amvd_pkg::amvd_sample_t last_sample;
  logic [10:0]            thr_shadow;
  int                     mismatches   = 0;
  int                     idle_cycles  = 0;
  bit                     running      = 1'b0;

  // Sender burst control
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  accel_motion_vote_detector_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // True when the size of the change between two signed raw samples is above the threshold
  function automatic bit axis_moved(input logic [9:0] cur, input logic [9:0] old,
                                    input logic [10:0] thr);
    int delta;
    delta = int'($signed(cur)) - int'($signed(old));
    if (delta < 0) delta = -delta;
    return delta > int'(thr);
  endfunction

  // Vote over the three axes
  function automatic vote_t predict_vote(input amvd_pkg::amvd_sample_t cur,
                                         input amvd_pkg::amvd_sample_t old,
                                         input logic [10:0] thr);
    int    count;
    vote_t v;
    count = int'(axis_moved(cur.x, old.x, thr)) + int'(axis_moved(cur.y, old.y, thr))
          + int'(axis_moved(cur.z, old.z, thr));
    v.axes   = 2'(count);
    v.motion = (count >= 2);
    return v;
  endfunction

  // Encode a signed axis value as low byte plus high byte with random upper bits
  function automatic logic [15:0] pack_axis(input int val);
    logic [9:0] raw;
    raw = 10'(val);
    return {6'($urandom_range(0, 63)), raw[9:8], raw[7:0]};
  endfunction

  // Pick the next value of one axis: random, near the threshold, small step or extreme
  function automatic int next_axis(input int last, input int thr);
    int pick;
    int delta;
    int val;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      val = int'($urandom_range(0, 1023)) - 512;
    end else if (pick == 9) begin
      val = $urandom_range(0, 1) ? 511 : -512;
    end else begin
      if (pick < 8) delta = thr + int'($urandom_range(0, 4)) - 2;
      else delta = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) delta = -delta;
      val = last + delta;
      if (val > 511 || val < -512) val = last - delta;
      if (val > 511 || val < -512) val = int'($urandom_range(0, 1023)) - 512;
    end
    return val;
  endfunction

  task automatic add_row(input logic [47:0] d, input bit typed, input logic motion,
                         input logic [1:0] axes);
    dir_row_t r;
    r.data        = d;
    r.typed       = typed;
    r.vote.motion = motion;
    r.vote.axes   = axes;
    dir_rows.push_back(r);
  endtask

  // Offer one request, hold it until accepted, then idle per burst pattern;
  // stop lowers valid and returns at the accepting edge
  task automatic send_request(input logic [47:0] d, input bit typed, input vote_t v,
                              input bit stop);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    row_typed <= typed;
    row_vote  <= v;
    do @(posedge clk); while (!in_tready);
    if (stop) begin
      in_tvalid <= 1'b0;
    end else if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Wait until every expected result has come back
  task automatic wait_drain();
    @(posedge clk);
    while (vote_q.size() != 0) @(posedge clk);
  endtask

  // APB write of the threshold: setup cycle, then access cycle
  task automatic write_threshold(input int thr);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= THRESH_ADDR;
    cfg_pwdata  <= 32'(thr);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Receiver: switch at random between always ready, random, fixed pattern and heavy stall
  int         stall_mode  = 0;
  int         stall_left  = 0;
  logic [7:0] stall_pat   = 8'b1011_0010;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_pat <= {stall_pat[6:0], stall_pat[7]};
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= stall_pat[7];
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Track config writes, predict on each accepted request, check each result
  always @(posedge clk) begin : track
    vote_t                  want;
    vote_t                  got;
    amvd_pkg::amvd_sample_t cur;
    bit                     moved;
    if (!rst_n) begin
      thr_shadow  = amvd_pkg::THRESH_RESET;
      last_sample = '0;
      vote_q.delete();
    end else begin
      moved = 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == THRESH_ADDR) thr_shadow = cfg_pwdata[10:0];
        moved = 1'b1;
      end
      // Check results before queuing new requests of the same edge
      if (out_tvalid && out_tready) begin
        moved      = 1'b1;
        got.motion = out_tdata[0];
        got.axes   = out_tdata[2:1];
        if (vote_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result: motion=%0d axes=%0d", got.motion, got.axes);
          mismatches++;
        end else begin
          want = vote_q.pop_front();
          if (got != want) begin
            if (mismatches < REPORT_LIMIT)
              $display("mismatch: expected motion=%0d axes=%0d, got motion=%0d axes=%0d",
                       want.motion, want.axes, got.motion, got.axes);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        cur.x = {in_tdata[9:8], in_tdata[7:0]};
        cur.y = {in_tdata[25:24], in_tdata[23:16]};
        cur.z = {in_tdata[41:40], in_tdata[39:32]};
        want  = predict_vote(cur, last_sample, thr_shadow);
        if (row_typed) want = row_vote;
        vote_q.push_back(want);
        last_sample = cur;
      end
      // Watchdog on cycles with no transfer of any kind
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (running && idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("** accel_motion_vote_detector_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int    thr_list[PHASE_COUNT];
    int    thr_now;
    int    gx;
    int    gy;
    int    gz;
    bit    stop;
    logic [47:0] d;

    thr_list = '{0, 2047, 1023, 1022, 1, 512, 0, 255};
    thr_list[6] = $urandom_range(2, 2046);
    gx = 0;
    gy = 0;
    gz = 0;

    // Directed rows at the reset threshold of 255
    // Data reads z_high z_low y_high y_low x_high x_low
    add_row(48'h00_00_00_00_00_00, 1, 1'b0, 2'd0); // first sample against zero history
    add_row(48'h00_00_01_FF_01_FF, 1, 1'b1, 2'd2); // two axes jump to +511
    add_row(48'h02_00_02_00_02_00, 1, 1'b1, 2'd3); // all to -512, full 1023 swing
    add_row(48'h01_FF_01_FF_01_FF, 1, 1'b1, 2'd3); // all back to +511
    add_row(48'hFD_FF_FD_FF_FD_FF, 1, 1'b0, 2'd0); // same values, unused high bits set
    add_row(48'hFF_FF_FF_FF_FF_FF, 1, 1'b1, 2'd3); // all to -1
    add_row(48'hFE_00_FE_00_FE_00, 1, 1'b1, 2'd3); // negative decode of -512
    add_row(48'h02_00_02_00_02_00, 1, 1'b0, 2'd0); // unused bits clear, no change
    add_row(48'h02_00_03_00_02_FF, 0, 1'b0, 2'd0); // change of exactly 255 vs 256
    add_row(48'h03_00_03_FF_03_FF, 0, 1'b0, 2'd0); // 256, 255 and 256 steps
    add_row(48'h54_01_A8_02_FC_03, 0, 1'b0, 2'd0);
    add_row(48'hFC_00_FC_00_FC_00, 0, 1'b0, 2'd0); // zero samples, upper bits set

    // Hold reset, then release
    repeat (8) @(posedge clk);
    rst_n   <= 1'b1;
    running  = 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].vote,
                   i == dir_rows.size() - 1);

    // Random phases, one threshold each, written while idle
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drain();
      write_threshold(thr_list[p]);
      thr_now = thr_list[p];
      gaps_on = (p % 3 != 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        gx = next_axis(gx, thr_now);
        gy = next_axis(gy, thr_now);
        gz = next_axis(gz, thr_now);
        d  = {pack_axis(gz), pack_axis(gy), pack_axis(gx)};
        stop = (k == PHASE_ITEMS - 1) || (p == 2 && k == PHASE_ITEMS / 2);
        send_request(d, 1'b0, '0, stop);
        // Pause mid-phase until the pipeline is empty
        if (p == 2 && k == PHASE_ITEMS / 2) wait_drain();
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && vote_q.size() == 0) begin
      $display("** accel_motion_vote_detector_top: PASSED **");
    end else begin
      $display("** accel_motion_vote_detector_top: FAILED **");
    end
    $finish;
  end

endmodule
